>>> design/sesc_pkg.sv
// shared types, constants and helper functions for the string escape decoder
// no dependencies
package sesc_pkg;

  localparam int unsigned MAX_RES = 5;
  localparam int unsigned RES_CNT_W = $clog2(MAX_RES + 1);

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_V      = 8'h76;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_ESC  = 3'd1,
    MODE_OCT  = 3'd2,
    MODE_HEX  = 3'd3,
    MODE_UNI  = 3'd4
  } sesc_mode_t;

  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      n;
  } sesc_utf8_t;

  typedef struct packed {
    logic [MAX_RES-1:0][7:0] bytes;
    logic [RES_CNT_W-1:0]    n;
    logic                    last;
  } sesc_res_t;

  function automatic sesc_utf8_t sesc_utf8(input logic [15:0] cp);
    sesc_utf8_t u;
    u = '0;
    if (cp <= 16'h007F) begin
      u.n        = 2'd1;
      u.bytes[0] = cp[7:0];
    end else if (cp <= 16'h07FF) begin
      u.n        = 2'd2;
      u.bytes[0] = 8'hC0 | {3'b000, cp[10:6]};
      u.bytes[1] = 8'h80 | {2'b00, cp[5:0]};
    end else begin
      u.n        = 2'd3;
      u.bytes[0] = 8'hE0 | {4'b0000, cp[15:12]};
      u.bytes[1] = 8'h80 | {2'b00, cp[11:6]};
      u.bytes[2] = 8'h80 | {2'b00, cp[5:0]};
    end
    return u;
  endfunction

  // bit 4 set when the byte is a hex digit, low nibble its value
  function automatic logic [4:0] sesc_hex(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      return {1'b1, c[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      t = c - 8'h57;
      return {1'b1, t[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      t = c - 8'h37;
      return {1'b1, t[3:0]};
    end
    return 5'b00000;
  endfunction

  function automatic logic [7:0] sesc_esc_map(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    case (c)
      CH_N:    r = 8'h0A;
      CH_R:    r = 8'h0D;
      CH_T:    r = 8'h09;
      CH_B:    r = 8'h08;
      CH_F:    r = 8'h0C;
      CH_V:    r = 8'h0B;
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

>>> design/string_escape_to_utf8_decoder_top.sv
// top level of the string escape decoder: input handshake, result buffer and output handshake
// depends on sesc_pkg and sesc_decode
//
// usage
//   input channel: in_valid / in_stall carry one raw literal byte (in_src_byte) and a
//   flag for the final byte of the literal (in_end_of_literal) per transfer
//   output channel: out_valid / out_stall carry one decoded byte per transfer;
//   out_run_end marks the last byte caused by an input byte, out_literal_end the
//   last byte of the whole literal
//   an input byte is decoded in the cycle it is taken and its results (zero to five
//   bytes) appear on the output from the next cycle on, one per cycle while out_stall is low
//   throughput: one input byte per cycle while each byte gives at most one result and
//   out_stall is low; a byte giving more results stalls the input until only its last
//   result is left, as the single output port drains the result buffer
//   a new byte is taken in the same cycle the last pending result transfers
//   a stalled output holds its byte and flags; the input is stalled meanwhile
//   reset clears the escape state and empties the result buffer
module string_escape_to_utf8_decoder_top import sesc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_src_byte,
  input  logic       in_end_of_literal,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_out_byte,
  output logic       out_run_end,
  output logic       out_literal_end
);

  sesc_res_t               res;
  logic                    in_acc;
  logic                    out_acc;
  logic [MAX_RES-1:0][7:0] bytes_r;
  logic [RES_CNT_W-1:0]    n_r;
  logic                    lit_r;

  assign in_stall = (n_r > RES_CNT_W'(1)) || (n_r == RES_CNT_W'(1) && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;

  sesc_decode u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc_i  (in_acc),
    .byte_i (in_src_byte),
    .last_i (in_end_of_literal),
    .res_o  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= '0;
    end else if (in_acc) begin
      n_r <= res.n;
    end else if (out_acc) begin
      n_r <= n_r - RES_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      bytes_r <= res.bytes;
      lit_r   <= res.last;
    end else if (out_acc) begin
      bytes_r <= bytes_r >> 8;
    end
  end

  assign out_valid       = (n_r != '0);
  assign out_out_byte    = bytes_r[0];
  assign out_run_end     = (n_r == RES_CNT_W'(1));
  assign out_literal_end = (n_r == RES_CNT_W'(1)) && lit_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && n_r != '0) |-> (n_r == RES_CNT_W'(1) && out_acc))
    else $error("pending results overwritten by new transfer");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= RES_CNT_W'(MAX_RES))
    else $error("result count out of range");

  a_drain_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && !in_acc) |=> (n_r == $past(n_r) - RES_CNT_W'(1)))
    else $error("result buffer did not advance after transfer");

endmodule

>>> design/sesc_decode.sv
// escape state machine: holds the escape state and builds the result bytes of one input byte
// depends on sesc_pkg
module sesc_decode import sesc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      acc_i,
  input  logic [7:0] byte_i,
  input  logic      last_i,
  output sesc_res_t res_o
);

  sesc_mode_t      mode_r, mode_nxt;
  logic [15:0]     code_r, code_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic [2:0][7:0] held_r;

  logic            hold_we;
  logic            is_oct;
  logic [4:0]      hexv;
  logic            done;
  logic            use_plain;
  logic            plain_n;
  logic [3:0][7:0] pre;
  logic [2:0]      pre_n;
  logic [15:0]     code_oct, code_hex;
  sesc_utf8_t      u_old, u_oct, u_hex;

  assign is_oct   = (byte_i[7:3] == 5'b00110);
  assign hexv     = sesc_hex(byte_i);
  assign code_oct = {code_r[12:0], byte_i[2:0]};
  assign code_hex = {code_r[11:0], hexv[3:0]};
  assign u_old    = sesc_utf8(code_r);
  assign u_oct    = sesc_utf8(code_oct);
  assign u_hex    = sesc_utf8(code_hex);

  always_comb begin
    mode_nxt  = mode_r;
    code_nxt  = code_r;
    cnt_nxt   = cnt_r;
    hold_we   = 1'b0;
    use_plain = 1'b0;
    plain_n   = 1'b0;
    done      = 1'b0;
    pre       = '0;
    pre_n     = 3'd0;
    unique case (mode_r)
      MODE_ESC: begin
        mode_nxt = MODE_IDLE;
        if (is_oct) begin
          code_nxt = {13'd0, byte_i[2:0]};
          cnt_nxt  = 2'd1;
          if (last_i) begin
            pre[0] = {5'd0, byte_i[2:0]};
            pre_n  = 3'd1;
          end else begin
            mode_nxt = MODE_OCT;
          end
        end else if (byte_i == CH_X || byte_i == CH_U) begin
          if (last_i) begin
            pre[0] = byte_i;
            pre_n  = 3'd1;
          end else begin
            mode_nxt = (byte_i == CH_X) ? MODE_HEX : MODE_UNI;
            code_nxt = '0;
            cnt_nxt  = 2'd0;
          end
        end else begin
          pre[0] = sesc_esc_map(byte_i);
          pre_n  = 3'd1;
        end
      end
      MODE_OCT: begin
        if (is_oct) begin
          code_nxt = code_oct;
          cnt_nxt  = cnt_r + 2'd1;
          if (cnt_r == 2'd2 || last_i) begin
            pre[2:0] = u_oct.bytes;
            pre_n    = {1'b0, u_oct.n};
            mode_nxt = MODE_IDLE;
          end
        end else begin
          pre[2:0]  = u_old.bytes;
          pre_n     = {1'b0, u_old.n};
          mode_nxt  = MODE_IDLE;
          use_plain = 1'b1;
        end
      end
      MODE_HEX, MODE_UNI: begin
        done = hexv[4] && ((mode_r == MODE_HEX) ? (cnt_r == 2'd1) : (cnt_r == 2'd3));
        if (done) begin
          code_nxt = code_hex;
          pre[2:0] = u_hex.bytes;
          pre_n    = {1'b0, u_hex.n};
          mode_nxt = MODE_IDLE;
        end else if (hexv[4] && !last_i) begin
          hold_we  = 1'b1;
          code_nxt = code_hex;
          cnt_nxt  = cnt_r + 2'd1;
        end else begin
          pre[0]    = (mode_r == MODE_HEX) ? CH_X : CH_U;
          pre[3:1]  = held_r;
          pre_n     = 3'd1 + {1'b0, cnt_r};
          mode_nxt  = MODE_IDLE;
          use_plain = 1'b1;
        end
      end
      default: begin
        mode_nxt  = MODE_IDLE;
        use_plain = 1'b1;
      end
    endcase
    if (use_plain) begin
      if (byte_i == CH_BSLASH && !last_i) begin
        mode_nxt = MODE_ESC;
      end else begin
        plain_n = 1'b1;
      end
    end
    if (last_i) begin
      mode_nxt = MODE_IDLE;
      cnt_nxt  = 2'd0;
      code_nxt = '0;
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (k < 4 && k < int'(pre_n)) begin
        res_o.bytes[k] = pre[k[1:0]];
      end else begin
        res_o.bytes[k] = byte_i;
      end
    end
    res_o.n    = RES_CNT_W'(pre_n) + RES_CNT_W'(plain_n);
    res_o.last = last_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      code_r <= '0;
      cnt_r  <= '0;
    end else if (acc_i) begin
      mode_r <= mode_nxt;
      code_r <= code_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_i && hold_we) begin
      held_r[cnt_r] <= byte_i;
    end
  end

  a_last_gives_output: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_i && last_i) |-> (res_o.n != '0))
    else $error("final byte produced no output");

  a_last_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_i && last_i) |=> (mode_r == MODE_IDLE && cnt_r == 2'd0 && code_r == '0))
    else $error("escape state not cleared after final byte");

  a_hex_count: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_HEX) |-> (cnt_r <= 2'd1))
    else $error("hex escape holds too many digits");

endmodule

>>> test/sesc_decode_check_pkg.sv
// predictor and scoreboard for the string escape decoder testbench
// depends on sesc_pkg for the escape mode type, character constants and result limit
package sesc_decode_check_pkg;
  import sesc_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       lit_end;
  } dec_byte_t;

  class escape_decode_predictor;
    sesc_mode_t  mode;
    logic [15:0] code;
    logic [2:0]  ndig;
    logic [7:0]  held [3];
    logic [7:0]  run_bytes [$];
    dec_byte_t   pending [$];
    int unsigned n_fail;

    function new();
      mode = MODE_IDLE;
      code = '0;
      ndig = '0;
      foreach (held[i]) held[i] = '0;
      n_fail = 0;
    endfunction

    function int hex_val(logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
    endfunction

    function void push_code_point(logic [15:0] cp);
      if (cp < 16'h0080) begin
        run_bytes.push_back(cp[7:0]);
      end else if (cp < 16'h0800) begin
        run_bytes.push_back({3'b110, cp[10:6]});
        run_bytes.push_back({2'b10, cp[5:0]});
      end else begin
        run_bytes.push_back({4'b1110, cp[15:12]});
        run_bytes.push_back({2'b10, cp[11:6]});
        run_bytes.push_back({2'b10, cp[5:0]});
      end
    endfunction

    function void plain_byte(logic [7:0] b, logic eol);
      if (b == CH_BSLASH && !eol) mode = MODE_ESC;
      else run_bytes.push_back(b);
    endfunction

    function void escape_letter(logic [7:0] b, logic eol);
      mode = MODE_IDLE;
      if (b >= "0" && b <= "7") begin
        code = {13'd0, b[2:0]};
        ndig = 3'd1;
        if (eol) push_code_point(code);
        else mode = MODE_OCT;
      end else if ((b == CH_X || b == CH_U) && !eol) begin
        mode = (b == CH_X) ? MODE_HEX : MODE_UNI;
        code = '0;
        ndig = '0;
      end else begin
        case (b)
          CH_N:    run_bytes.push_back(8'h0A);
          CH_R:    run_bytes.push_back(8'h0D);
          CH_T:    run_bytes.push_back(8'h09);
          CH_B:    run_bytes.push_back(8'h08);
          CH_F:    run_bytes.push_back(8'h0C);
          CH_V:    run_bytes.push_back(8'h0B);
          default: run_bytes.push_back(b);
        endcase
      end
    endfunction

    // broken run: letter, held digits, then the breaking byte as plain input
    function void hex_digit_in(logic [7:0] b, logic eol, int unsigned need, logic [7:0] letter);
      int h;
      int i;
      h = hex_val(b);
      if (h >= 0 && ndig + 1 == need) begin
        code = {code[11:0], h[3:0]};
        push_code_point(code);
        mode = MODE_IDLE;
      end else if (h >= 0 && !eol && ndig < 3) begin
        held[ndig] = b;
        code = {code[11:0], h[3:0]};
        ndig++;
      end else begin
        run_bytes.push_back(letter);
        for (i = 0; i < ndig && i < 3; i++) run_bytes.push_back(held[i]);
        mode = MODE_IDLE;
        plain_byte(b, eol);
      end
    endfunction

    function void take_byte(logic [7:0] b, logic eol);
      dec_byte_t r;
      int n;
      run_bytes.delete();
      case (mode)
        MODE_ESC: escape_letter(b, eol);
        MODE_OCT: begin
          if (b >= "0" && b <= "7") begin
            code = {code[12:0], b[2:0]};
            ndig++;
            if (ndig >= 3 || eol) begin
              push_code_point(code);
              mode = MODE_IDLE;
            end
          end else begin
            push_code_point(code);
            mode = MODE_IDLE;
            plain_byte(b, eol);
          end
        end
        MODE_HEX: hex_digit_in(b, eol, 2, CH_X);
        MODE_UNI: hex_digit_in(b, eol, 4, CH_U);
        default: begin
          mode = MODE_IDLE;
          plain_byte(b, eol);
        end
      endcase
      if (eol) begin
        mode = MODE_IDLE;
        ndig = '0;
        code = '0;
      end
      n = (run_bytes.size() > MAX_RES) ? MAX_RES : run_bytes.size();
      for (int k = 0; k < n; k++) begin
        r.data    = run_bytes[k];
        r.run_end = (k == n - 1);
        r.lit_end = (k == n - 1) && eol;
        pending.push_back(r);
      end
    endfunction

    function void match_byte(logic [7:0] data, logic run_end, logic lit_end);
      dec_byte_t want;
      if (pending.size() == 0) begin
        $error("unexpected result transfer: out_byte %h", data);
        n_fail++;
        return;
      end
      want = pending.pop_front();
      if (data !== want.data) begin
        $error("out_byte: expected %h, got %h", want.data, data);
        n_fail++;
      end
      if (run_end !== want.run_end) begin
        $error("run_end: expected %b, got %b", want.run_end, run_end);
        n_fail++;
      end
      if (lit_end !== want.lit_end) begin
        $error("literal_end: expected %b, got %b", want.lit_end, lit_end);
        n_fail++;
      end
    endfunction
  endclass

endpackage

>>> test/string_escape_to_utf8_decoder_top_test.sv
// top-level testbench for the string escape decoder: directed and random literals
// under varying input gaps and output stalls; depends on sesc_pkg and sesc_decode_check_pkg
module string_escape_to_utf8_decoder_top_test import sesc_pkg::*, sesc_decode_check_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_src_byte = 8'h00;
  logic       in_end_of_literal = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_out_byte;
  logic       out_run_end;
  logic       out_literal_end;

  escape_decode_predictor decoder_pred = new();
  logic [7:0]  lit_q [$];
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned n_rand;

  string_escape_to_utf8_decoder_top DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_src_byte(in_src_byte),
    .in_end_of_literal(in_end_of_literal),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_out_byte(out_out_byte),
    .out_run_end(out_run_end),
    .out_literal_end(out_literal_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("string_escape_to_utf8_decoder_top verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      decoder_pred.match_byte(out_out_byte, out_run_end, out_literal_end);
    end
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  task automatic send_byte(input logic [7:0] b, input logic eol);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_src_byte       <= b;
    in_end_of_literal <= eol;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decoder_pred.take_byte(b, eol);
  endtask

  task automatic send_lit();
    foreach (lit_q[i]) send_byte(lit_q[i], i == lit_q.size() - 1);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 10) return 8'h30 + {4'h0, v};
    return 8'(($urandom_range(1) ? 8'h41 : 8'h61) + {4'h0, v} - 8'd10);
  endfunction

  task automatic add_token();
    int unsigned kind;
    int unsigned n;
    logic [15:0] v;
    logic [7:0]  b;
    kind = $urandom_range(11);
    case (kind)
      0, 1, 2: begin
        b = 8'($urandom_range(255));
        lit_q.push_back(b);
      end
      3: begin
        lit_q.push_back(CH_BSLASH);
        case ($urandom_range(9))
          0: b = CH_N;
          1: b = CH_R;
          2: b = CH_T;
          3: b = CH_B;
          4: b = CH_F;
          5: b = CH_V;
          6: b = "\"";
          7: b = "'";
          8: b = CH_BSLASH;
          default: b = 8'($urandom_range(255));
        endcase
        lit_q.push_back(b);
      end
      4, 5: begin
        lit_q.push_back(CH_BSLASH);
        n = $urandom_range(3, 1);
        repeat (n) begin
          b = 8'("0" + $urandom_range(7));
          lit_q.push_back(b);
        end
      end
      6: begin
        v = 16'($urandom_range(255));
        lit_q.push_back(CH_BSLASH);
        lit_q.push_back(CH_X);
        lit_q.push_back(hex_char(v[7:4]));
        lit_q.push_back(hex_char(v[3:0]));
      end
      7, 8: begin
        case ($urandom_range(2))
          0:       v = 16'($urandom_range(16'h007F));
          1:       v = 16'($urandom_range(16'h07FF, 16'h0080));
          default: v = 16'($urandom_range(16'hFFFF, 16'h0800));
        endcase
        lit_q.push_back(CH_BSLASH);
        lit_q.push_back(CH_U);
        lit_q.push_back(hex_char(v[15:12]));
        lit_q.push_back(hex_char(v[11:8]));
        lit_q.push_back(hex_char(v[7:4]));
        lit_q.push_back(hex_char(v[3:0]));
      end
      9, 10: begin
        lit_q.push_back(CH_BSLASH);
        lit_q.push_back(kind == 9 ? CH_X : CH_U);
        n = $urandom_range(kind == 9 ? 1 : 3);
        repeat (n) begin
          v = 16'($urandom_range(15));
          lit_q.push_back(hex_char(v[3:0]));
        end
        if ($urandom_range(3) == 0) begin
          b = CH_BSLASH;
        end else begin
          do b = 8'($urandom_range(255)); while (decoder_pred.hex_val(b) >= 0);
        end
        lit_q.push_back(b);
      end
      default: begin
        n = $urandom_range(3, 1);
        repeat (n) begin
          case ($urandom_range(3))
            0:       b = CH_BSLASH;
            1:       b = 8'("0" + $urandom_range(9));
            2:       b = $urandom_range(1) ? CH_X : CH_U;
            default: b = 8'($urandom_range(255));
          endcase
          lit_q.push_back(b);
        end
      end
    endcase
  endtask

  initial begin
    int unsigned n;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    lit_q = {8'h00, 8'hFF, CH_BSLASH, CH_N};
    send_lit();
    lit_q = {CH_BSLASH, "3", "7", "7", CH_BSLASH, CH_X, "4", "1"};
    send_lit();
    lit_q = {CH_BSLASH, CH_U, "F", "F", "F", "F", CH_BSLASH, CH_U, "1", "2", "3", "g"};
    send_lit();
    lit_q = {CH_BSLASH};
    send_lit();

    n_rand = 0;
    while (n_rand < 380) begin
      if (n_rand >= 285) begin
        idle_pct  = 8;
        stall_pct = 8;
      end else if (n_rand >= 190) begin
        idle_pct  = 0;
        stall_pct = 61;
      end else if (n_rand >= 95) begin
        idle_pct  = 61;
        stall_pct = 0;
      end
      lit_q.delete();
      repeat ($urandom_range(6, 1)) add_token();
      // cut some literals short, often inside an escape
      if ($urandom_range(99) < 15) begin
        n = $urandom_range(lit_q.size(), 1);
        lit_q = lit_q[0:n-1];
      end
      send_lit();
      n_rand += lit_q.size();
    end
    in_valid <= 1'b0;

    while (decoder_pred.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (decoder_pred.n_fail == 0) begin
      $display("string_escape_to_utf8_decoder_top verification clean");
    end else begin
      $display("string_escape_to_utf8_decoder_top verification failed");
    end
    $finish;
  end

endmodule
